### rtl/ps2prt_pkg.sv
// Shared types, codes and helpers of the PS/2 port response tracker.
`timescale 1ns / 1ps

package ps2prt_pkg;

  // Default depth of the response store per port
  localparam int DEF_RESPONSE_DEPTH = 16;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Address width that covers both port halves at the largest depth
  localparam int STORE_ADDR_W = 5;

  // Command word operations
  typedef enum logic [2:0] {
    OP_RX    = 3'd0,
    OP_START = 3'd1,
    OP_SENT  = 3'd2,
    OP_DONE  = 3'd3,
    OP_END   = 3'd4
  } op_t;

  // Port flag bit positions
  localparam int FL_WAIT_ACK  = 0;
  localparam int FL_WAIT_CMD  = 1;
  localparam int FL_WAIT_RESP = 2;
  localparam int FL_GET_ID    = 3;
  localparam int FL_PASS      = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_SECOND_PORT = 3'd0;
  localparam logic [2:0] REG_GET_ID      = 3'd1;
  localparam logic [2:0] REG_SET_LEDS    = 3'd2;
  localparam logic [2:0] REG_SET_LEDS_EX = 3'd3;
  localparam logic [2:0] REG_SET_REP     = 3'd4;
  localparam logic [2:0] REG_RESET       = 3'd5;

  // Result kinds
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_PASS   = 3'd1,
    EV_WAKE   = 3'd2,
    EV_RESP   = 3'd3,
    EV_STATUS = 3'd4
  } event_kind_t;

  // Register file contents
  typedef struct packed {
    logic       second_port_present;
    logic [7:0] get_id_opcode;
    logic [7:0] set_leds_opcode;
    logic [7:0] set_leds_ex_opcode;
    logic [7:0] set_rep_opcode;
    logic [7:0] reset_opcode;
  } cfg_t;

  // One classified word from front to back
  typedef struct packed {
    logic        is_end;
    event_kind_t kind;
    logic        port;
    logic [7:0]  value;
    logic        ack;
    logic        ok;
    logic [3:0]  count;
  } job_t;

  // Map a port and an entry index to a store address
  function automatic logic [STORE_ADDR_W-1:0] store_addr(logic port, logic [3:0] idx,
                                                         int depth);
    logic [STORE_ADDR_W-1:0] base;
    base = port ? STORE_ADDR_W'(depth) : '0;
    return base + STORE_ADDR_W'(idx);
  endfunction

endpackage

### rtl/ps2prt_if.sv
// Handshake channels for command words and result words.
`timescale 1ns / 1ps

interface ps2prt_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic       port_select;
  logic [7:0] data_byte;
  logic [3:0] response_count;

  modport source (output valid, output operation, output port_select,
                  output data_byte, output response_count, input ready);
  modport sink (input valid, input operation, input port_select,
                input data_byte, input response_count, output ready);
endinterface

interface ps2prt_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic       port_number;
  logic [7:0] byte_value;
  logic       ack_seen;
  logic       command_ok;
  logic       last;

  modport source (output valid, output event_kind, output port_number,
                  output byte_value, output ack_seen, output command_ok,
                  output last, input ready);
  modport sink (input valid, input event_kind, input port_number,
                input byte_value, input ack_seen, input command_ok,
                input last, output ready);
endinterface

### rtl/ps2prt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ps2prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ps2prt_fifo.sv
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module ps2prt_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  ps2prt_pkg::job_t    push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output ps2prt_pkg::job_t    pop_data
);

  localparam int PW = $clog2(ps2prt_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(ps2prt_pkg::QUEUE_DEPTH + 1);

  ps2prt_pkg::job_t entries [ps2prt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != CW'(ps2prt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(ps2prt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(ps2prt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/ps2prt_front.sv
// Front end: accepts command words, updates port state, classifies results.
`timescale 1ns / 1ps

module ps2prt_front #(
  parameter int RESPONSE_DEPTH = ps2prt_pkg::DEF_RESPONSE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  ps2prt_cmd_if.sink                           cmd,
  input  ps2prt_pkg::cfg_t                     cfg,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output ps2prt_pkg::job_t                     push_data,
  input  logic                                 store_done,
  output logic                                 mem_we,
  output logic [$clog2(2*RESPONSE_DEPTH)-1:0]  mem_waddr,
  output logic [7:0]                           mem_wdata,
  output logic [2*RESPONSE_DEPTH-1:0]          entry_valid
);

  localparam int AW = $clog2(2 * RESPONSE_DEPTH);

  // Bytes with a fixed meaning during the acknowledge phase
  localparam logic [7:0] ACK_BYTE   = 8'hFA;
  localparam logic [7:0] NACK_BYTE  = 8'hFE;
  localparam logic [7:0] ID_BYTE_FC = 8'hFC;
  localparam logic [7:0] ID_BYTE_00 = 8'h00;
  localparam logic [7:0] ID_BYTE_03 = 8'h03;
  localparam logic [7:0] ID_BYTE_04 = 8'h04;

  logic [4:0] flags    [2];
  logic       ack      [2];
  logic [3:0] rem      [2];
  logic [3:0] expct    [2];
  logic [7:0] opc      [2];
  logic       busy;

  logic       rdy;
  logic       accept;
  logic       port;
  logic [7:0] din;
  logic [3:0] cnt_sat;
  logic [4:0] f;
  logic       a;
  logic [3:0] r;
  logic       is_start;
  logic       store_we;
  logic [3:0] store_idx;
  ps2prt_pkg::job_t job;

  assign rdy        = push_ready && !busy;
  assign cmd.ready  = rdy;
  assign accept     = cmd.valid && rdy;
  assign port       = cmd.port_select;
  assign din        = cmd.data_byte;
  assign push_valid = accept;
  assign push_data  = job;
  assign mem_we     = accept && store_we;
  assign mem_waddr  = AW'(ps2prt_pkg::store_addr(port, store_idx, RESPONSE_DEPTH));
  assign mem_wdata  = din;

  // Saturate the response count to the store depth
  assign cnt_sat = ({1'b0, cmd.response_count} > 5'(RESPONSE_DEPTH)) ?
                   4'(RESPONSE_DEPTH) : cmd.response_count;

  // Classify the word and work out the next port state
  always_comb begin
    logic is_ack;
    logic do_resp;
    is_ack    = 1'b0;
    do_resp   = 1'b0;
    f         = flags[port];
    a         = ack[port];
    r         = rem[port];
    is_start  = 1'b0;
    store_we  = 1'b0;
    store_idx = '0;
    job       = '0;
    job.kind  = ps2prt_pkg::EV_NONE;
    job.port  = port;

    unique case (ps2prt_pkg::op_t'(cmd.operation))
      ps2prt_pkg::OP_RX: begin
        if (port && !cfg.second_port_present) begin
          // drop aux byte, no port state change
        end else if (f[ps2prt_pkg::FL_WAIT_ACK]) begin
          case (din) inside
            ACK_BYTE: begin
              a      = 1'b1;
              is_ack = 1'b1;
            end
            NACK_BYTE: begin
              a      = 1'b0;
              is_ack = 1'b1;
            end
            ID_BYTE_FC, ID_BYTE_00, ID_BYTE_03, ID_BYTE_04: begin
              is_ack = f[ps2prt_pkg::FL_GET_ID];
              if (is_ack) begin
                a = 1'b1;
              end
            end
            default: is_ack = 1'b0;
          endcase
          if (!is_ack) begin
            if (f[ps2prt_pkg::FL_PASS]) begin
              job.kind  = ps2prt_pkg::EV_PASS;
              job.value = din;
            end
            f[ps2prt_pkg::FL_GET_ID] = 1'b0;
            f[ps2prt_pkg::FL_PASS]   = 1'b0;
          end else begin
            f[ps2prt_pkg::FL_WAIT_ACK] = 1'b0;
            if (a && din != ACK_BYTE) begin
              do_resp = 1'b1;
            end else begin
              job.kind = ps2prt_pkg::EV_WAKE;
            end
          end
        end else if (f[ps2prt_pkg::FL_WAIT_CMD]) begin
          do_resp = 1'b1;
        end else begin
          job.kind  = ps2prt_pkg::EV_PASS;
          job.value = din;
        end

        // Response phase: store byte in reverse order, wake waiters
        if (do_resp) begin
          if (r != '0) begin
            r         = r - 1'b1;
            store_we  = 1'b1;
            store_idx = r;
          end
          if (f[ps2prt_pkg::FL_WAIT_RESP]) begin
            f[ps2prt_pkg::FL_WAIT_RESP] = 1'b0;
            if (r != '0) begin
              job.kind = ps2prt_pkg::EV_WAKE;
            end
          end
          if (r == '0) begin
            f[ps2prt_pkg::FL_WAIT_CMD] = 1'b0;
            job.kind                   = ps2prt_pkg::EV_WAKE;
          end
        end
      end
      ps2prt_pkg::OP_START: begin
        is_start = 1'b1;
        r        = cnt_sat;
        if (din == cfg.get_id_opcode) begin
          f[ps2prt_pkg::FL_GET_ID] = 1'b1;
        end else if (din == cfg.set_leds_opcode || din == cfg.set_leds_ex_opcode ||
                     din == cfg.set_rep_opcode) begin
          f[ps2prt_pkg::FL_PASS] = 1'b1;
        end else begin
          f = '0;
        end
        if (cnt_sat != '0) begin
          f[ps2prt_pkg::FL_WAIT_CMD]  = 1'b1;
          f[ps2prt_pkg::FL_WAIT_RESP] = 1'b1;
        end
      end
      ps2prt_pkg::OP_SENT: begin
        a                          = 1'b0;
        f[ps2prt_pkg::FL_WAIT_ACK] = 1'b1;
      end
      ps2prt_pkg::OP_DONE: begin
        f[ps2prt_pkg::FL_WAIT_ACK] = 1'b0;
        if (!a) begin
          f = '0;
        end
        job.kind = ps2prt_pkg::EV_STATUS;
        job.ok   = a;
      end
      ps2prt_pkg::OP_END: begin
        job.is_end = 1'b1;
        job.kind   = ps2prt_pkg::EV_STATUS;
        job.count  = expct[port];
        job.ok     = !(r != '0 && (opc[port] != cfg.reset_opcode || r != 4'd1));
        f          = '0;
      end
      default: begin
        // unused codes leave state alone
      end
    endcase
    job.ack = a;
  end

  // Hold port state, store validity and the busy mark
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        flags[i] <= '0;
        ack[i]   <= 1'b0;
        rem[i]   <= '0;
        expct[i] <= '0;
        opc[i]   <= '0;
      end
      entry_valid <= '0;
      busy        <= 1'b0;
    end else begin
      if (accept) begin
        flags[port] <= f;
        ack[port]   <= a;
        rem[port]   <= r;
        if (is_start) begin
          expct[port] <= cnt_sat;
          opc[port]   <= din;
          for (int j = 0; j < RESPONSE_DEPTH; j++) begin
            if (port) begin
              entry_valid[RESPONSE_DEPTH + j] <= 1'b0;
            end else begin
              entry_valid[j] <= 1'b0;
            end
          end
        end
        if (store_we) begin
          entry_valid[mem_waddr] <= 1'b1;
        end
      end
      if (accept && job.is_end) begin
        busy <= 1'b1;
      end else if (store_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### rtl/ps2prt_back.sv
// Back end: turns queued words into result words, replays stored responses.
`timescale 1ns / 1ps

module ps2prt_back #(
  parameter int RESPONSE_DEPTH = ps2prt_pkg::DEF_RESPONSE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  output logic                                 q_ready,
  input  ps2prt_pkg::job_t                     q_data,
  output logic                                 rd_en,
  output logic [$clog2(2*RESPONSE_DEPTH)-1:0]  rd_addr,
  input  logic [7:0]                           rd_data,
  input  logic [2*RESPONSE_DEPTH-1:0]          entry_valid,
  output logic                                 store_done,
  ps2prt_evt_if.source                         evt
);

  localparam int AW = $clog2(2 * RESPONSE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STATUS
  } state_t;

  state_t      state;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic        out_port;
  logic [7:0]  out_byte;
  logic        out_ack;
  logic        out_ok;
  logic        out_last;
  logic        job_port;
  logic        job_ok;
  logic        job_ack;
  logic [3:0]  remain;
  logic [AW-1:0] cur_addr;
  logic        slot_free;
  logic        pop;
  logic        load;

  assign evt.valid       = out_valid;
  assign evt.event_kind  = out_kind;
  assign evt.port_number = out_port;
  assign evt.byte_value  = out_byte;
  assign evt.ack_seen    = out_ack;
  assign evt.command_ok  = out_ok;
  assign evt.last        = out_last;

  assign slot_free  = !out_valid || evt.ready;
  assign q_ready    = pop;
  assign store_done = (state == ST_STATUS) && slot_free;

  // Pop queue, issue store reads and decide when the output word loads
  always_comb begin
    pop     = 1'b0;
    load    = 1'b0;
    rd_en   = 1'b0;
    rd_addr = cur_addr;
    unique case (state)
      ST_IDLE: begin
        if (slot_free && q_valid) begin
          pop = 1'b1;
          if (!q_data.is_end) begin
            load = 1'b1;
          end
          if (q_data.is_end && q_data.count != '0) begin
            rd_en   = 1'b1;
            rd_addr = AW'(ps2prt_pkg::store_addr(q_data.port, q_data.count - 4'd1,
                                                 RESPONSE_DEPTH));
          end
        end
      end
      ST_READ: begin
        load = slot_free;
        if (slot_free && remain != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(ps2prt_pkg::store_addr(job_port, remain - 4'd1, RESPONSE_DEPTH));
        end
      end
      ST_STATUS: begin
        // status needs no read
        load = slot_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Sequence results and hold the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (q_data.is_end) begin
              job_port <= q_data.port;
              job_ok   <= q_data.ok;
              job_ack  <= q_data.ack;
              if (q_data.count != '0) begin
                remain   <= q_data.count - 4'd1;
                cur_addr <= rd_addr;
                state    <= ST_READ;
              end else begin
                state <= ST_STATUS;
              end
            end else begin
              out_kind  <= q_data.kind;
              out_port  <= q_data.port;
              out_byte  <= q_data.value;
              out_ack   <= q_data.ack;
              out_ok    <= q_data.ok;
              out_last  <= 1'b1;
            end
          end
        end
        ST_READ: begin
          if (slot_free) begin
            out_kind  <= ps2prt_pkg::EV_RESP;
            out_port  <= job_port;
            out_byte  <= entry_valid[cur_addr] ? rd_data : 8'd0;
            out_ack   <= job_ack;
            out_ok    <= 1'b0;
            out_last  <= 1'b0;
            if (remain != '0) begin
              remain   <= remain - 4'd1;
              cur_addr <= rd_addr;
            end else begin
              state <= ST_STATUS;
            end
          end
        end
        ST_STATUS: begin
          if (slot_free) begin
            out_kind  <= ps2prt_pkg::EV_STATUS;
            out_port  <= job_port;
            out_byte  <= 8'd0;
            out_ack   <= job_ack;
            out_ok    <= job_ok;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ps2_port_response_tracker.sv
// Path: each result is held in the queue, then loaded into the registered output word.
// Throughput: one word per cycle unless the queue or the output stalls; end command
//   emits its stored responses one per cycle from the store RAM read port while the
//   output is free, then a status, and holds cmd.ready low from its acceptance until
//   that status is loaded.
// Reset: synchronous; clears port state and store entry valid bits.
`timescale 1ns / 1ps

module ps2_port_response_tracker #(
  parameter int RESPONSE_DEPTH = ps2prt_pkg::DEF_RESPONSE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  ps2prt_cmd_if.sink   cmd,
  ps2prt_evt_if.source evt,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = $clog2(2 * RESPONSE_DEPTH);

  ps2prt_pkg::cfg_t cfg;
  logic [2:0]       reg_idx;

  logic             push_valid;
  logic             push_ready;
  ps2prt_pkg::job_t push_data;
  logic             q_valid;
  logic             q_ready;
  ps2prt_pkg::job_t q_data;
  logic             store_done;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic [2*RESPONSE_DEPTH-1:0] entry_valid;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.second_port_present <= 1'b0;
      cfg.get_id_opcode       <= 8'd242;
      cfg.set_leds_opcode     <= 8'd237;
      cfg.set_leds_ex_opcode  <= 8'd235;
      cfg.set_rep_opcode      <= 8'd243;
      cfg.reset_opcode        <= 8'd255;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        ps2prt_pkg::REG_SECOND_PORT: cfg.second_port_present <= pwdata[0];
        ps2prt_pkg::REG_GET_ID:      cfg.get_id_opcode       <= pwdata[7:0];
        ps2prt_pkg::REG_SET_LEDS:    cfg.set_leds_opcode     <= pwdata[7:0];
        ps2prt_pkg::REG_SET_LEDS_EX: cfg.set_leds_ex_opcode  <= pwdata[7:0];
        ps2prt_pkg::REG_SET_REP:     cfg.set_rep_opcode      <= pwdata[7:0];
        ps2prt_pkg::REG_RESET:       cfg.reset_opcode        <= pwdata[7:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      ps2prt_pkg::REG_SECOND_PORT: prdata = {31'd0, cfg.second_port_present};
      ps2prt_pkg::REG_GET_ID:      prdata = {24'd0, cfg.get_id_opcode};
      ps2prt_pkg::REG_SET_LEDS:    prdata = {24'd0, cfg.set_leds_opcode};
      ps2prt_pkg::REG_SET_LEDS_EX: prdata = {24'd0, cfg.set_leds_ex_opcode};
      ps2prt_pkg::REG_SET_REP:     prdata = {24'd0, cfg.set_rep_opcode};
      ps2prt_pkg::REG_RESET:       prdata = {24'd0, cfg.reset_opcode};
      default:                     prdata = 32'd0;
    endcase
  end

  ps2prt_front #(
    .RESPONSE_DEPTH(RESPONSE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .store_done (store_done),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .entry_valid(entry_valid)
  );

  ps2prt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  ps2prt_ram #(
    .WIDTH(8),
    .DEPTH(2 * RESPONSE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  ps2prt_back #(
    .RESPONSE_DEPTH(RESPONSE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .entry_valid(entry_valid),
    .store_done (store_done),
    .evt        (evt)
  );

endmodule
